[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[hdl/imr_pkg.sv]
// ----------------------------------------------------------------------------
// ICMP reply matcher package
// Shared types, constants and codes for the ICMP reply matcher.
// ----------------------------------------------------------------------------
package imr_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 65535;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQUENCE = 1'd1;

    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    localparam int INNER_HEADER_SKIP = 8;
    localparam int SRC_FIRST         = 12;
    localparam int ID_LOW_OFFSET     = 4;
    localparam int ID_HIGH_OFFSET    = 5;
    localparam int SEQ_LOW_OFFSET    = 6;
    localparam int SEQ_HIGH_OFFSET   = 7;
    localparam int LAST_HEADER_BYTE  = 15;

    localparam logic [1:0] CLASS_OTHER         = 2'd0;
    localparam logic [1:0] CLASS_TIME_EXCEEDED = 2'd1;
    localparam logic [1:0] CLASS_ECHO_REPLY    = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic        matched;
        logic        reached_destination;
        logic [1:0]  reply_class;
        logic [31:0] sender_address;
        logic        truncated;
    } t_result;

endpackage

[hdl/icmp_reply_matcher_top.sv]
// ----------------------------------------------------------------------------
// ICMP reply matcher, top level
// Matches received IPv4 packets against the expected probe identifier and
// sequence and reports one verdict beat per packet.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle with no gaps of its own: a byte
// passes from the input register through the offset tracker, and the
// verdict of a packet lands in the result register at the same edge at
// which its last byte leaves the input register. The result register lets
// the next packet stream in while a verdict waits; only a last byte that
// meets a full result register waits. Configuration writes are always taken.
module icmp_reply_matcher_top #(
    parameter int MAX_PACKET_BYTES = imr_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_packet_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_matched,
    output logic                          o_reached_destination,
    output logic [1:0]                    o_reply_class,
    output logic [31:0]                   o_sender_address,
    output logic                          o_truncated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [imr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [imr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0]      r_expected_id;
    logic [7:0]       r_expected_sequence;
    imr_pkg::t_beat   w_in_beat, w_beat;
    imr_pkg::t_result w_result, w_out;
    logic             w_beat_valid, w_fire, w_out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id       <= '0;
            r_expected_sequence <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                imr_pkg::CFG_EXPECTED_ID: begin
                    r_expected_id <= i_cfg_data;
                end
                imr_pkg::CFG_EXPECTED_SEQUENCE: begin
                    r_expected_sequence <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_in_beat.data = i_packet_byte;
    assign w_in_beat.last = i_last_byte;
    assign w_fire = w_beat_valid && (w_out_free || !w_beat.last);

    imr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_beat    (w_in_beat),
        .i_advance (w_fire),
        .o_ready   (o_in_ready),
        .o_valid   (w_beat_valid),
        .o_beat    (w_beat)
    );

    imr_tracker #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_tracker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_fire              (w_fire),
        .i_beat              (w_beat),
        .i_expected_id       (r_expected_id),
        .i_expected_sequence (r_expected_sequence),
        .o_result            (w_result)
    );

    imr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire && w_beat.last),
        .i_result (w_result),
        .i_ready  (i_out_ready),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .o_result (w_out)
    );

    assign o_matched             = w_out.matched;
    assign o_reached_destination = w_out.reached_destination;
    assign o_reply_class         = w_out.reply_class;
    assign o_sender_address      = w_out.sender_address;
    assign o_truncated           = w_out.truncated;

endmodule

[hdl/imr_in_reg.sv]
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted packet byte until the tracker consumes it.
// ----------------------------------------------------------------------------
module imr_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  imr_pkg::t_beat i_beat,
    input  logic          i_advance,
    output logic          o_ready,
    output logic          o_valid,
    output imr_pkg::t_beat o_beat
);

    logic           r_valid;
    imr_pkg::t_beat r_beat;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

[hdl/imr_tracker.sv]
// ----------------------------------------------------------------------------
// Packet tracker
// Follows the byte offset through one packet, captures the header fields
// and forms the verdict for the final byte.
// ----------------------------------------------------------------------------
module imr_tracker #(
    parameter int MAX_PACKET_BYTES = imr_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  imr_pkg::t_beat   i_beat,
    input  logic [15:0]      i_expected_id,
    input  logic [7:0]       i_expected_sequence,
    output imr_pkg::t_result o_result
);

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CW = (PW > 9) ? PW : 9;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_PACKET_BYTES);
    localparam logic [CW-1:0] SKIP    = CW'(imr_pkg::INNER_HEADER_SKIP);

    logic [PW-1:0] r_pos,   n_pos;
    logic [5:0]    r_icmp,  n_icmp;
    logic [7:0]    r_echo,  n_echo;
    logic [7:0]    r_type,  n_type;
    logic [15:0]   r_id,    n_id;
    logic [15:0]   r_seq,   n_seq;
    logic [31:0]   r_src,   n_src;

    logic [CW-1:0] w_pos, w_icmp_old, w_echo_old;
    logic [CW-1:0] w_cnt, w_icmp_new, w_echo_new;
    logic [3:0]    w_nib;
    logic          w_short, w_type_known, w_accepted;
    logic [1:0]    w_class;

    assign w_nib      = i_beat.data[3:0];
    assign w_pos      = CW'(r_pos);
    assign w_icmp_old = CW'(r_icmp);
    assign w_echo_old = CW'(r_echo);
    assign w_cnt      = CW'(n_pos);
    assign w_icmp_new = CW'(n_icmp);
    assign w_echo_new = CW'(n_echo);

    always_comb begin
        n_pos  = r_pos;
        n_icmp = r_icmp;
        n_echo = r_echo;
        n_type = r_type;
        n_id   = r_id;
        n_seq  = r_seq;
        n_src  = r_src;
        if (r_pos < POS_MAX) begin
            if (r_pos == '0) begin
                n_icmp = {w_nib, 2'b00};
                n_echo = {2'b00, w_nib, 2'b00};
            end
            if (w_pos == CW'(n_icmp)) begin
                n_type = i_beat.data;
                n_echo = {2'b00, n_icmp};
            end
            if (w_pos > w_icmp_old && r_type == imr_pkg::TYPE_TIME_EXCEEDED &&
                w_pos == w_icmp_old + SKIP) begin
                n_echo = 8'(w_icmp_old + SKIP) + {2'b00, w_nib, 2'b00};
            end
            if (w_pos == CW'(imr_pkg::SRC_FIRST)) begin
                n_src[31:24] = i_beat.data;
            end
            if (w_pos == CW'(imr_pkg::SRC_FIRST + 1)) begin
                n_src[23:16] = i_beat.data;
            end
            if (w_pos == CW'(imr_pkg::SRC_FIRST + 2)) begin
                n_src[15:8] = i_beat.data;
            end
            if (w_pos == CW'(imr_pkg::SRC_FIRST + 3)) begin
                n_src[7:0] = i_beat.data;
            end
            if (w_pos == w_echo_old + CW'(imr_pkg::ID_LOW_OFFSET)) begin
                n_id[7:0] = i_beat.data;
            end else if (w_pos == w_echo_old + CW'(imr_pkg::ID_HIGH_OFFSET)) begin
                n_id[15:8] = i_beat.data;
            end else if (w_pos == w_echo_old + CW'(imr_pkg::SEQ_LOW_OFFSET)) begin
                n_seq[7:0] = i_beat.data;
            end else if (w_pos == w_echo_old + CW'(imr_pkg::SEQ_HIGH_OFFSET)) begin
                n_seq[15:8] = i_beat.data;
            end
            n_pos = r_pos + PW'(1);
        end
    end

    always_comb begin
        w_short = (w_cnt <= CW'(imr_pkg::LAST_HEADER_BYTE)) || (w_cnt <= w_icmp_new);
        if (n_type == imr_pkg::TYPE_TIME_EXCEEDED) begin
            w_short = w_short || (w_cnt <= w_icmp_new + SKIP) ||
                      (w_cnt <= w_echo_new + CW'(imr_pkg::SEQ_HIGH_OFFSET));
        end else if (n_type == imr_pkg::TYPE_ECHO_REPLY) begin
            w_short = w_short || (w_cnt <= w_echo_new + CW'(imr_pkg::SEQ_HIGH_OFFSET));
        end
        w_type_known = w_cnt > w_icmp_new;
        w_class      = imr_pkg::CLASS_OTHER;
        if (w_type_known && n_type == imr_pkg::TYPE_TIME_EXCEEDED) begin
            w_class = imr_pkg::CLASS_TIME_EXCEEDED;
        end else if (w_type_known && n_type == imr_pkg::TYPE_ECHO_REPLY) begin
            w_class = imr_pkg::CLASS_ECHO_REPLY;
        end
        w_accepted = w_class != imr_pkg::CLASS_OTHER;

        o_result.matched = !w_short && w_accepted && (n_id == i_expected_id) &&
                           (n_seq == {8'h00, i_expected_sequence});
        o_result.reached_destination = o_result.matched &&
                                       (w_class == imr_pkg::CLASS_ECHO_REPLY);
        o_result.reply_class    = w_class;
        o_result.sender_address = n_src;
        o_result.truncated      = w_short;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_beat.last)) begin
            r_pos  <= '0;
            r_icmp <= '0;
            r_echo <= '0;
            r_type <= '0;
            r_id   <= '0;
            r_seq  <= '0;
            r_src  <= '0;
        end else if (i_fire) begin
            r_pos  <= n_pos;
            r_icmp <= n_icmp;
            r_echo <= n_echo;
            r_type <= n_type;
            r_id   <= n_id;
            r_seq  <= n_seq;
            r_src  <= n_src;
        end
    end

endmodule

[hdl/imr_out_reg.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one packet verdict until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module imr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  imr_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output imr_pkg::t_result o_result
);

    logic             r_valid;
    imr_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[hdl/imr_checker.sv]
// ----------------------------------------------------------------------------
// ICMP reply matcher checker
// Port-level checks on the packet and verdict beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_packet_byte,
    input logic        i_last_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_matched,
    input logic        o_reached_destination,
    input logic [1:0]  o_reply_class,
    input logic [31:0] o_sender_address,
    input logic        o_truncated
);

    `ASSERT_CLK(a_in_held,
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_packet_byte) &&
        $stable(i_last_byte),
        "Packet beat dropped or changed while stalled.")
    `ASSERT_CLK(a_out_held,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sender_address) &&
        $stable(o_matched) && $stable(o_reply_class) && $stable(o_truncated),
        "Verdict beat dropped or changed while stalled.")
    `ASSERT_NEVER(a_match_clean,
        o_out_valid && o_matched &&
        (o_truncated || o_reply_class == imr_pkg::CLASS_OTHER),
        "Match reported for a truncated or foreign packet.")
    `ASSERT_NEVER(a_dest_match,
        o_out_valid && o_reached_destination &&
        !(o_matched && o_reply_class == imr_pkg::CLASS_ECHO_REPLY),
        "Destination reached without an echo reply match.")

endmodule

bind icmp_reply_matcher_top imr_checker u_imr_checker (.*);
